@@ sv/arst_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and classification functions for the address range
// symbol table. No dependencies; imported by every module of the block.
package arst_pkg;

  // Table depth and derived widths
  localparam int MAX_ENTRIES = 256;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Stream widths: fields packed from bit 0 up, padded to whole bytes
  localparam int IN_FIELDS_W  = 32 + 32 + 4 + 4 + 2 + 32 + 1;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 3 + 8 + 32 + 2 + 2;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Request modes carried in tuser
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_LOAD   = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_FILTERED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_CLEARED   = 3'd5
  } status_t;

  // Symbol type, binding and visibility codes
  localparam logic [3:0] TYPE_OBJECT  = 4'd1;
  localparam logic [3:0] TYPE_FUNC    = 4'd2;
  localparam logic [3:0] TYPE_SECTION = 4'd3;
  localparam logic [3:0] BIND_LOCAL   = 4'd0;
  localparam logic [1:0] VIS_DEFAULT  = 2'd0;

  // Kind and visibility class codes
  localparam logic [1:0] KIND_OBJECT  = 2'd0;
  localparam logic [1:0] KIND_FUNC    = 2'd1;
  localparam logic [1:0] KIND_OTHER   = 2'd2;
  localparam logic [1:0] VCL_LOCAL    = 2'd0;
  localparam logic [1:0] VCL_PRIVATE  = 2'd1;
  localparam logic [1:0] VCL_PUBLIC   = 2'd2;

  // One stored table entry
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic [1:0]  kind;
    logic [1:0]  vclass;
  } entry_t;

  // Range check result from the compare unit
  typedef struct packed {
    logic        hit;
    logic [31:0] offset;
  } match_t;

  // One result item
  typedef struct packed {
    status_t     status;
    logic [7:0]  index;
    logic [31:0] offset;
    logic [1:0]  kind;
    logic [1:0]  vclass;
  } res_t;

  function automatic logic [1:0] kind_of(input logic [3:0] sym_type);
    logic [1:0] k;
    case (sym_type)
      TYPE_OBJECT: k = KIND_OBJECT;
      TYPE_FUNC:   k = KIND_FUNC;
      default:     k = KIND_OTHER;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] vclass_of(input logic [3:0] bind_code,
                                           input logic [1:0] vis);
    logic [1:0] v;
    if (bind_code == BIND_LOCAL) begin
      v = VCL_LOCAL;
    end else if (vis != VIS_DEFAULT) begin
      v = VCL_PRIVATE;
    end else begin
      v = VCL_PUBLIC;
    end
    return v;
  endfunction

endpackage

@@ sv/arst_mem.sv @@
`timescale 1ns / 1ps
// Entry storage of the symbol table: one write port, one registered read port.
// Depends on arst_pkg for the entry type and depth.
module arst_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [arst_pkg::IDX_W-1:0] wr_addr,
  input  arst_pkg::entry_t          wr_data,
  input  logic [arst_pkg::IDX_W-1:0] rd_addr,
  output arst_pkg::entry_t          rd_data
);
  import arst_pkg::*;

  entry_t mem [MAX_ENTRIES];

  // Write and registered read; contents are undefined until written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/arst_match.sv @@
`timescale 1ns / 1ps
// Shared range compare unit: checks one entry against the query address and
// forms the offset. Depends on arst_pkg for the entry and match types.
module arst_match (
  input  arst_pkg::entry_t entry,
  input  logic [31:0]      addr,
  input  logic             ret_mode,
  output arst_pkg::match_t result
);
  import arst_pkg::*;

  logic [31:0] range_end;
  logic        hit_norm;
  logic        hit_ret;

  // End wraps modulo 2^32
  assign range_end = entry.start + entry.size;

  // Normal: [start, end); return address: (start, end]
  assign hit_norm = (addr >= entry.start) && (addr < range_end);
  assign hit_ret  = (addr > entry.start) && (addr <= range_end);

  assign result.hit    = ret_mode ? hit_ret : hit_norm;
  assign result.offset = addr - entry.start;

endmodule

@@ sv/address_range_symbol_table.sv @@
`timescale 1ns / 1ps
// Address range symbol table, top level: request sequencer, entry storage and
// the shared range compare unit. Depends on arst_pkg, arst_mem, arst_match.
//
// Usage:
//   Requests arrive on the in_ stream; in_tuser selects clear, load or
//   lookup, in_tdata carries the symbol and query fields. Each clear, load
//   or lookup returns one result on the out_ stream; the unused mode is
//   dropped without a result.
//   Clear and load: the result is registered in the emit state and then moved
//   to the output register; the next request can be taken after that.
//   Lookup: entries are read from the table memory and checked by the one
//   compare unit at one entry per cycle, in load order, stopping at the first
//   hit. At most the entry count (at most 256) entries are checked, and the
//   result then passes the emit state; an empty table skips the scan.
//   in_tready is high only while the sequencer is idle.
//   The result sits in an output register; a stalled receiver holds it there,
//   and the block still takes one more request and finishes its work, which
//   then waits until the output register frees up.
//   Reset (rst_n low, synchronous) empties the table and drops any pending
//   result. Table memory is not cleared; entries are read only after writes.
module address_range_symbol_table (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: symbol_start, symbol_size, symbol_type, symbol_binding,
  //           symbol_visibility, query_address, return_mode, zero pad
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [arst_pkg::IN_DATA_W-1:0] in_tdata,
  // in_tuser: mode
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_tdata: status, entry_index, offset, kind, visibility_class, zero pad
  output logic [arst_pkg::OUT_DATA_W-1:0] out_tdata
);
  import arst_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  // Request field unpacking
  logic [31:0] f_start;
  logic [31:0] f_size;
  logic [3:0]  f_type;
  logic [3:0]  f_bind;
  logic [1:0]  f_vis;
  logic [31:0] f_addr;
  logic        f_ret;
  mode_t       f_mode;

  assign f_start = in_tdata[31:0];
  assign f_size  = in_tdata[63:32];
  assign f_type  = in_tdata[67:64];
  assign f_bind  = in_tdata[71:68];
  assign f_vis   = in_tdata[73:72];
  assign f_addr  = in_tdata[105:74];
  assign f_ret   = in_tdata[106];
  assign f_mode  = mode_t'(in_tuser);

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        chk_r, chk_nxt;
  logic [31:0]             addr_r, addr_nxt;
  logic                    ret_r, ret_nxt;
  res_t                    res_r, res_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]   out_tdata_r, out_tdata_nxt;

  logic                    in_fire;
  logic                    wr_en;
  entry_t                  wr_data;
  logic [IDX_W-1:0]        rd_addr;
  entry_t                  rd_data;
  match_t                  match;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  arst_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  arst_match u_match (
    .entry    (rd_data),
    .addr     (addr_r),
    .ret_mode (ret_r),
    .result   (match)
  );

  // Sequencer next-state logic
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    chk_nxt        = chk_r;
    addr_nxt       = addr_r;
    ret_nxt        = ret_r;
    res_nxt        = res_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    wr_en          = 1'b0;
    wr_data.start  = f_start;
    wr_data.size   = f_size;
    wr_data.kind   = kind_of(f_type);
    wr_data.vclass = vclass_of(f_bind, f_vis);
    rd_addr        = chk_r + IDX_W'(1);

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (in_fire) begin
          res_nxt = '0;
          case (f_mode)
            MODE_CLEAR: begin
              cnt_nxt        = '0;
              res_nxt.status = ST_CLEARED;
              state_nxt      = S_EMIT;
            end
            MODE_LOAD: begin
              state_nxt = S_EMIT;
              if (f_start == 32'd0 || f_type == TYPE_SECTION) begin
                res_nxt.status = ST_FILTERED;
              end else if (cnt_r == CNT_W'(MAX_ENTRIES)) begin
                res_nxt.status = ST_FULL;
              end else begin
                wr_en          = 1'b1;
                cnt_nxt        = cnt_r + CNT_W'(1);
                res_nxt.status = ST_STORED;
                res_nxt.index  = 8'(cnt_r);
                res_nxt.kind   = wr_data.kind;
                res_nxt.vclass = wr_data.vclass;
              end
            end
            MODE_LOOKUP: begin
              addr_nxt = f_addr;
              ret_nxt  = f_ret;
              chk_nxt  = '0;
              if (cnt_r == '0) begin
                res_nxt.status = ST_NOT_FOUND;
                state_nxt      = S_EMIT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // One entry checked per cycle; read of the next entry issued alongside
      S_SCAN: begin
        if (match.hit) begin
          res_nxt.status = ST_FOUND;
          res_nxt.index  = 8'(chk_r);
          res_nxt.offset = match.offset;
          res_nxt.kind   = rd_data.kind;
          res_nxt.vclass = rd_data.vclass;
          state_nxt      = S_EMIT;
        end else if (CNT_W'(chk_r) + CNT_W'(1) == cnt_r) begin
          res_nxt.status = ST_NOT_FOUND;
          state_nxt      = S_EMIT;
        end else begin
          chk_nxt = chk_r + IDX_W'(1);
        end
      end

      // Hand the result to the output register once it is free
      S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_DATA_W'({res_r.vclass, res_r.kind, res_r.offset,
                                        res_r.index, res_r.status});
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      chk_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      chk_r        <= chk_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    addr_r      <= addr_nxt;
    ret_r       <= ret_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

`ifndef ASSERT_OFF
  // Fill count never passes the table depth
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table depth");

  // Scan pointer stays inside the filled part of the table
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CNT_W'(chk_r) < cnt_r))
    else $error("scan past last stored entry");

  // The unused mode leaves the sequencer idle and the table untouched
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && f_mode == MODE_UNUSED) |=> (state_r == S_IDLE && $stable(cnt_r)))
    else $error("unused mode changed state");

  // A kept load grows the table by exactly one
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && wr_en) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("stored entry did not advance count");

  // A finished result is not dropped while the output is stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_tvalid_r && !out_tready) |=> (state_r == S_EMIT))
    else $error("result left pending state during stall");
`endif

endmodule
